### rtl/lsbp_pkg.sv
// Package with mode codes and controller/datapath handshake types for the bit packer.
`default_nettype none

package lsbp_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_ZERO  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam int unsigned FIELD_MAX_BITS = 64;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned WORD_BITS      = FIELD_MAX_BITS + BYTE_BITS;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take the accepted item
    logic push;  // emit one result into the output register
  } lsbp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic rem_last;  // next result is the last one of the item
  } lsbp_stat_t;

endpackage

`default_nettype wire

### rtl/lsbp_ctrl.sv
// Controller state machine for the bit packer: accept, then emit results.
`default_nettype none

module lsbp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lsbp_pkg::lsbp_stat_t stat,
  output lsbp_pkg::lsbp_cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from the current state
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          if (stat.rem_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the input side while results of the current item drain
  assign in_stall = (state_r != S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lsbp_dpath.sv
// Datapath for the bit packer: bit alignment, byte shifter, pending state, output register.
`default_nettype none

module lsbp_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           in_mode,
  input  wire logic [63:0]          in_value,
  input  wire logic [6:0]           in_bit_count,
  input  wire lsbp_pkg::lsbp_cmd_t  cmd,
  output lsbp_pkg::lsbp_stat_t      stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_byte_valid,
  output logic                      out_last
);

  localparam int unsigned WordW = lsbp_pkg::WORD_BITS;

  // Pending partial byte and its fill level
  logic [7:0]       partial_r, partial_nxt;
  logic [2:0]       offset_r, offset_nxt;
  // Bytes of the current item, lowest first
  logic [63:0]      acc_r;
  logic [3:0]       count_r;
  logic             nobyte_r;
  // Output register
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_byte_valid_r;
  logic             out_last_r;

  logic [63:0]      mask;
  logic [63:0]      field;
  logic [WordW-1:0] word;
  logic [7:0]       bit_sum;
  logic [3:0]       nbytes;
  logic [6:0]       sel;

  // Align the new field behind the pending bits
  always_comb begin
    if (in_bit_count >= 7'(lsbp_pkg::FIELD_MAX_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({64{1'b1}} << in_bit_count[5:0]);
    end
    field = (in_mode == lsbp_pkg::MODE_WRITE) ? (in_value & mask) : '0;
    bit_sum = {5'b0, offset_r} + {1'b0, in_bit_count};
    sel = 7'd0;
    word = (WordW'(field) << offset_r) | WordW'(partial_r);
    partial_nxt = partial_r;
    offset_nxt  = offset_r;
    nbytes      = 4'd0;
    unique case (in_mode) inside
      lsbp_pkg::MODE_WRITE, lsbp_pkg::MODE_ZERO: begin
        if (in_bit_count <= 7'(lsbp_pkg::FIELD_MAX_BITS)) begin
          nbytes      = bit_sum[6:3];
          sel         = {bit_sum[6:3], 3'b000};
          partial_nxt = word[sel +: 8];
          offset_nxt  = bit_sum[2:0];
        end
      end
      lsbp_pkg::MODE_FLUSH: begin
        word        = WordW'(partial_r);
        nbytes      = (offset_r != 3'd0) ? 4'd1 : 4'd0;
        partial_nxt = '0;
        offset_nxt  = '0;
      end
      default: begin
        partial_nxt = '0;
        offset_nxt  = '0;
      end
    endcase
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.rem_last = (count_r == 4'd1);

  // Update pending state and the byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      offset_r  <= '0;
      count_r   <= '0;
      nobyte_r  <= 1'b0;
    end else if (cmd.load) begin
      partial_r <= partial_nxt;
      offset_r  <= offset_nxt;
      count_r   <= (nbytes == 4'd0) ? 4'd1 : nbytes;
      nobyte_r  <= (nbytes == 4'd0);
    end else if (cmd.push) begin
      count_r <= count_r - 4'd1;
    end
  end

  // Load the item's bytes, then shift one byte out per result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= word[63:0];
    end else if (cmd.push) begin
      acc_r <= {8'b0, acc_r[63:8]};
    end
  end

  // Output register: fill on push, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte_r       <= nobyte_r ? 8'd0 : acc_r[7:0];
      out_byte_valid_r <= !nobyte_r;
      out_last_r       <= (count_r == 4'd1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

### rtl/lsb_first_bit_packer.sv
// Top level of the LSB-first bit packer: controller plus datapath.
//
// Input channel (in_valid/in_stall): one transfer carries in_mode, in_value and
// in_bit_count. Write places the low in_bit_count bits of in_value behind the
// pending bits, zero-fill appends zero bits, flush pads out the pending byte,
// clear drops it. Counts above 64 in write and zero-fill leave state as is.
// Result channel (out_valid/out_stall): one transfer per completed byte, in
// stream order, bit 0 first; an item completing no byte gives one result with
// out_byte_valid low. out_last marks the final result of an item.
// Timing: an item is accepted, then its K results (K = 1..8) leave the byte
// shifter one per cycle while the receiver does not stall; acceptance is
// registered in the state register before the first result enters the
// output register. The byte shifter sets the rate, one byte per cycle unstalled.
// A receiver stall freezes the output register and the shifter; in_stall stays
// high until the last result of the item is in the output register.
// Synchronous reset (rst_n low) empties the pending byte and output register.
`default_nettype none

module lsb_first_bit_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_value,
  input  wire logic [6:0]  in_bit_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last
);

  lsbp_pkg::lsbp_cmd_t  cmd;
  lsbp_pkg::lsbp_stat_t stat;

  lsbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsbp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### rtl/lsbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
`default_nettype none

module lsbp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_last
);

  // An accepted item holds the input side on the next cycle
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held after transfer");

  // A result without a byte is always the only and last one
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_byte == 8'd0))
    else $error("no-byte result malformed");

  // The input side opens only once a last result is in the output register or went out
  a_open_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> $past(out_valid && out_last && !out_stall) || out_valid)
    else $error("input reopened before last result");

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind lsb_first_bit_packer lsbp_checker u_lsbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_last       (out_last)
);

`default_nettype wire
